// ===== src/fwms_pkg.sv =====
package fwms_pkg;

    // longest word kept, further characters are dropped
    localparam int MAX_LEN = 64;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int CHAR_W  = 8;

    // result width and saturation value
    localparam int GAIN_W = 15;
    localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

    // walk accumulators, sized for words up to 128 characters
    localparam int EVAL_W  = 24;
    localparam int DELTA_W = 14;

    // scoring constants
    localparam int RUN_START    = 2;
    localparam int RUN_STEP     = 10;
    localparam int TAIL_COST    = 10;
    localparam int MIN_WALK_LEN = 3;
    localparam int PAIR_LEN     = 2;
    localparam int PAIR_BONUS   = 10;
    localparam int LEN_SLACK    = 2;

    // command codes
    localparam logic CMD_PATTERN   = 1'b0;
    localparam logic CMD_CANDIDATE = 1'b1;

    // queue between front and back, depth is a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // classified beat handed from front to back
    typedef struct packed {
        logic              is_cand;
        logic [CHAR_W-1:0] ch;
        logic              eow;
        logic              finish;
        logic              eon;
    } t_beat;

endpackage

// ===== src/fwms_front.sv =====
module fwms_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_cmd,
    input  logic [7:0]            i_ch,
    input  logic                  i_end_of_word,
    input  logic                  i_end_of_node,
    output logic                  o_beat_valid,
    output fwms_pkg::t_beat       o_beat,
    input  logic                  i_beat_take
);

    fwms_pkg::t_beat r_q [fwms_pkg::QUEUE_DEPTH];
    logic [fwms_pkg::QPTR_W-1:0] r_wr;
    logic [fwms_pkg::QPTR_W-1:0] r_rd;
    logic [fwms_pkg::QCNT_W-1:0] r_cnt;
    fwms_pkg::t_beat             w_beat;
    logic                        w_push_ok;
    logic                        w_take_ok;

    // classify the incoming beat
    always_comb begin
        w_beat.is_cand = (i_cmd == fwms_pkg::CMD_CANDIDATE);
        w_beat.ch      = i_ch;
        w_beat.eow     = i_end_of_word;
        w_beat.finish  = w_beat.is_cand && (i_end_of_word || i_end_of_node);
        w_beat.eon     = w_beat.is_cand && i_end_of_node;
    end

    assign full         = (r_cnt == fwms_pkg::QCNT_W'(fwms_pkg::QUEUE_DEPTH));
    assign w_push_ok    = push && !full;
    assign o_beat_valid = (r_cnt != '0);
    assign w_take_ok    = i_beat_take && o_beat_valid;
    assign o_beat       = r_q[r_rd];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_q[r_wr] <= w_beat;
        end
    end

    // queue pointers, wrap on the power-of-two depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push_ok) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_take_ok) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push_ok && !w_take_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push_ok && w_take_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== src/fwms_back.sv =====
module fwms_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_beat_valid,
    input  fwms_pkg::t_beat               i_beat,
    output logic                          o_beat_take,
    output logic                          o_out_valid,
    output logic [fwms_pkg::GAIN_W-1:0]   o_out_gain,
    input  logic                          i_pop
);

    localparam int LW = fwms_pkg::LEN_W;
    localparam int AW = fwms_pkg::ADDR_W;
    localparam int CW = fwms_pkg::CHAR_W;
    localparam int GW = fwms_pkg::GAIN_W;
    localparam int EW = fwms_pkg::EVAL_W;
    localparam int DW = fwms_pkg::DELTA_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // word stores
    logic [CW-1:0] r_pat_mem  [fwms_pkg::MAX_LEN];
    logic [CW-1:0] r_cand_mem [fwms_pkg::MAX_LEN];

    logic [1:0]            r_state, n_state;
    logic [LW-1:0]         r_pl, n_pl;
    logic [LW-1:0]         r_cl, n_cl;
    logic                  r_complete, n_complete;
    logic [GW-1:0]         r_best, n_best;
    logic [GW-1:0]         r_bonus, n_bonus;
    logic                  r_eon_pend, n_eon_pend;
    logic                  r_out_valid;
    logic [GW-1:0]         r_out_gain;
    logic [LW-1:0]         r_i, n_i;
    logic [LW-1:0]         r_j, n_j;
    logic signed [EW-1:0]  r_eval, n_eval;
    logic signed [DW-1:0]  r_delta, n_delta;
    logic [CW-1:0]         r_p0, n_p0, r_p1, n_p1;
    logic [CW-1:0]         r_c0, n_c0, r_c1, n_c1;
    logic [CW-1:0]         r_pa, r_pb, r_ca, r_cb;

    logic [LW-1:0]         n_i1, n_j1;
    logic                  w_take;
    logic                  w_emit;
    logic [GW-1:0]         w_emit_gain;
    logic                  w_pat_we, w_cand_we;
    logic [AW-1:0]         w_pat_addr, w_cand_addr;
    logic [LW-1:0]         w_pl_eff;
    logic [LW-1:0]         w_cl_new;
    logic                  w_walk_needed;
    logic                  w_cand_stall;
    logic                  w_out_free;
    logic                  w_pair_hit;
    logic [GW:0]           w_bonus_sum;
    logic [GW-1:0]         w_bonus_new;
    logic [CW-1:0]         w_cand0, w_cand1;
    logic signed [DW-1:0]  w_delta_new;
    logic [EW-1:0]         w_tail;
    logic signed [EW-1:0]  w_e;
    logic [GW-1:0]         w_u;
    logic [GW-1:0]         w_best_new;

    assign w_out_free  = !r_out_valid || i_pop;
    assign o_beat_take = w_take;
    assign o_out_valid = r_out_valid;
    assign o_out_gain  = r_out_gain;

    // candidate length after this beat, and whether the finished word is walked
    always_comb begin
        w_cl_new = (r_cl < LW'(fwms_pkg::MAX_LEN)) ? r_cl + 1'b1 : r_cl;
        w_walk_needed = i_beat.finish
                     && (r_pl >= LW'(fwms_pkg::MIN_WALK_LEN))
                     && (({1'b0, w_cl_new} + (LW+1)'(fwms_pkg::LEN_SLACK)) >= {1'b0, r_pl});
        w_cand_stall = i_beat.is_cand && i_beat.eon && !w_walk_needed && !w_out_free;
        w_pl_eff = r_complete ? '0 : r_pl;
    end

    // two-letter bonus check on the first characters
    always_comb begin
        w_cand0 = (r_cl == '0) ? i_beat.ch : r_c0;
        w_cand1 = (r_cl == LW'(1)) ? i_beat.ch : r_c1;
        w_pair_hit = (w_cl_new >= LW'(fwms_pkg::PAIR_LEN))
                  && (r_p0 == w_cand0) && (r_p1 == w_cand1);
        w_bonus_sum = {1'b0, r_bonus} + (GW+1)'(fwms_pkg::PAIR_BONUS);
        w_bonus_new = w_bonus_sum[GW] ? fwms_pkg::GAIN_MAX : w_bonus_sum[GW-1:0];
    end

    // one walk step: run credit or penalty, with one-character lookahead
    always_comb begin
        if (r_pa == r_ca) begin
            w_delta_new = (r_delta[DW-1] || r_delta == '0) ? DW'(fwms_pkg::RUN_START)
                                                          : r_delta + DW'(fwms_pkg::RUN_STEP);
        end else begin
            w_delta_new = !r_delta[DW-1] ? DW'(-fwms_pkg::RUN_START)
                                         : r_delta - DW'(fwms_pkg::RUN_STEP);
        end
    end

    // end of walk: pattern tail cost, clamp and best update
    always_comb begin
        w_tail = EW'(r_pl - r_i) * EW'(fwms_pkg::TAIL_COST);
        w_e    = r_eval - $signed(w_tail);
        w_u    = (w_e[EW-2:GW] != '0) ? fwms_pkg::GAIN_MAX : w_e[GW-1:0];
        w_best_new = (!w_e[EW-1] && w_e != '0 && w_u > r_best) ? w_u : r_best;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_pl        = r_pl;
        n_cl        = r_cl;
        n_complete  = r_complete;
        n_best      = r_best;
        n_bonus     = r_bonus;
        n_eon_pend  = r_eon_pend;
        n_i         = r_i;
        n_j         = r_j;
        n_eval      = r_eval;
        n_delta     = r_delta;
        n_p0        = r_p0;
        n_p1        = r_p1;
        n_c0        = r_c0;
        n_c1        = r_c1;
        w_take      = 1'b0;
        w_emit      = 1'b0;
        w_emit_gain = '0;
        w_pat_we    = 1'b0;
        w_cand_we   = 1'b0;
        w_pat_addr  = w_pl_eff[AW-1:0];
        w_cand_addr = r_cl[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                n_i = '0;
                n_j = '0;
                if (i_beat_valid && !w_cand_stall) begin
                    w_take = 1'b1;
                    if (!i_beat.is_cand) begin
                        // pattern beat, a finished pattern is replaced
                        if (r_complete) begin
                            n_cl    = '0;
                            n_best  = '0;
                            n_bonus = '0;
                        end
                        n_pl = w_pl_eff;
                        if (w_pl_eff < LW'(fwms_pkg::MAX_LEN)) begin
                            w_pat_we = 1'b1;
                            n_pl     = w_pl_eff + 1'b1;
                        end
                        if (w_pl_eff == '0) begin
                            n_p0 = i_beat.ch;
                        end
                        if (w_pl_eff == LW'(1)) begin
                            n_p1 = i_beat.ch;
                        end
                        n_complete = i_beat.eow;
                    end else begin
                        // candidate beat
                        w_cand_we = (r_cl < LW'(fwms_pkg::MAX_LEN));
                        n_c0 = w_cand0;
                        n_c1 = w_cand1;
                        if (w_walk_needed) begin
                            n_cl       = w_cl_new;
                            n_eon_pend = i_beat.eon;
                            n_state    = S_START;
                        end else begin
                            n_cl = i_beat.finish ? '0 : w_cl_new;
                            if (i_beat.finish && r_pl == LW'(fwms_pkg::PAIR_LEN)
                                    && w_pair_hit) begin
                                n_bonus = w_bonus_new;
                            end
                            if (i_beat.eon) begin
                                w_emit = 1'b1;
                                if (r_pl >= LW'(fwms_pkg::MIN_WALK_LEN)) begin
                                    w_emit_gain = r_best;
                                end else if (r_pl == LW'(fwms_pkg::PAIR_LEN)) begin
                                    w_emit_gain = w_pair_hit ? w_bonus_new : r_bonus;
                                end
                                n_best  = '0;
                                n_bonus = '0;
                            end
                        end
                    end
                end
            end
            S_START: begin
                // stores settled, fetch the first characters
                n_i     = '0;
                n_j     = '0;
                n_eval  = '0;
                n_delta = '0;
                n_state = S_WALK;
            end
            S_WALK: begin
                if (r_i < r_pl && r_j < r_cl) begin
                    n_delta = w_delta_new;
                    n_eval  = r_eval + {{(EW-DW){w_delta_new[DW-1]}}, w_delta_new};
                    if (r_pa == r_ca) begin
                        n_i = r_i + 1'b1;
                        n_j = r_j + 1'b1;
                    end else if ((({1'b0, r_i} + 1'b1) < {1'b0, r_pl}) && r_pb == r_ca) begin
                        n_i = r_i + 1'b1;
                    end else if ((({1'b0, r_j} + 1'b1) < {1'b0, r_cl}) && r_pa == r_cb) begin
                        n_j = r_j + 1'b1;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_j = r_j + 1'b1;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (r_eon_pend) begin
                    if (w_out_free) begin
                        w_emit      = 1'b1;
                        w_emit_gain = w_best_new;
                        n_best      = '0;
                        n_bonus     = '0;
                        n_cl        = '0;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_best  = w_best_new;
                    n_cl    = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_i1 = n_i + 1'b1;
    assign n_j1 = n_j + 1'b1;

    // stores: one write and two registered reads each
    always_ff @(posedge i_clk) begin
        if (w_pat_we) begin
            r_pat_mem[w_pat_addr] <= i_beat.ch;
        end
        if (w_cand_we) begin
            r_cand_mem[w_cand_addr] <= i_beat.ch;
        end
        r_pa <= r_pat_mem[n_i[AW-1:0]];
        r_pb <= r_pat_mem[n_i1[AW-1:0]];
        r_ca <= r_cand_mem[n_j[AW-1:0]];
        r_cb <= r_cand_mem[n_j1[AW-1:0]];
    end

    // walk datapath and first-character copies
    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_eval  <= n_eval;
        r_delta <= n_delta;
        r_p0    <= n_p0;
        r_p1    <= n_p1;
        r_c0    <= n_c0;
        r_c1    <= n_c1;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pl       <= '0;
            r_cl       <= '0;
            r_complete <= 1'b0;
            r_best     <= '0;
            r_bonus    <= '0;
            r_eon_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pl       <= n_pl;
            r_cl       <= n_cl;
            r_complete <= n_complete;
            r_best     <= n_best;
            r_bonus    <= n_bonus;
            r_eon_pend <= n_eon_pend;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_gain <= w_emit_gain;
        end
    end

    // walk indices never run past the word lengths
    a_walk_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_i <= r_pl && r_j <= r_cl))
        else $error("walk index beyond word length");

    // stored lengths stay within the stores
    a_len_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pl <= LW'(fwms_pkg::MAX_LEN)) && (r_cl <= LW'(fwms_pkg::MAX_LEN)))
        else $error("word length beyond store depth");

    // a node end without a walk gives a result on the next cycle
    a_node_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && w_take && i_beat.eon && !w_walk_needed) |=> r_out_valid)
        else $error("node end produced no result");

    // a result is never written over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (!r_out_valid || i_pop))
        else $error("result overwritten before pop");

endmodule

// ===== src/fuzzy_word_match_score.sv =====
// Typo-tolerant scoring of a pattern word against the candidate words of a node.
// Input channel (push/full): one character beat per push; i_cmd selects pattern
// (0) or candidate (1), i_end_of_word closes a word, i_end_of_node on a candidate
// beat closes the node and causes exactly one result. A beat is taken when push
// is high and full is low; a four-entry queue sits ahead of the scoring engine.
// Result channel (empty/pop): o_node_gain is valid while empty is low and is
// taken on a cycle with pop high; a one-entry result register holds it.
// The engine takes a character beat while idle. A candidate word that is walked
// then passes S_START, S walk steps in S_WALK (at most pattern length + candidate
// length, set by the single-step walk over the two stores) and S_DONE.
// A node end without a walk shows its result in the cycle after the one that
// takes it; with a walk, S_DONE registers it. While the result register is full
// and not popped, the engine holds at the next node end and the input queue
// fills, then full rises. Reset clears lengths, scores, the input queue and the
// result register; the character stores are not cleared and need no clearing pass.
module fuzzy_word_match_score (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         i_cmd,
    input  logic [7:0]                   i_ch,
    input  logic                         i_end_of_word,
    input  logic                         i_end_of_node,
    output logic                         empty,
    input  logic                         pop,
    output logic [14:0]                  o_node_gain
);

    fwms_pkg::t_beat              w_beat;
    logic                         w_beat_valid;
    logic                         w_beat_take;
    logic                         w_out_valid;
    logic [fwms_pkg::GAIN_W-1:0]  w_out_gain;

    // classify and queue beats
    fwms_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_cmd         (i_cmd),
        .i_ch          (i_ch),
        .i_end_of_word (i_end_of_word),
        .i_end_of_node (i_end_of_node),
        .o_beat_valid  (w_beat_valid),
        .o_beat        (w_beat),
        .i_beat_take   (w_beat_take)
    );

    // store words, walk and keep the node score
    fwms_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_valid (w_beat_valid),
        .i_beat       (w_beat),
        .o_beat_take  (w_beat_take),
        .o_out_valid  (w_out_valid),
        .o_out_gain   (w_out_gain),
        .i_pop        (pop)
    );

    assign empty       = !w_out_valid;
    assign o_node_gain = w_out_gain;

endmodule
